[sv/bpa_pkg.sv]
package bpa_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_BLOCK   = 2'd1,
		ST_BAD_ORDER  = 2'd2,
		ST_MISALIGNED = 2'd3
	} status_t;

endpackage

[sv/buddy_page_allocator_top.sv]
// Binary buddy page allocator: one sequencer works one transaction at a time.
// A transaction is taken when start is high and busy is low. Its result shows
// on status and block_index, marked by done, which is high for exactly one
// cycle. The receiver cannot stall, so it must take the result in that cycle.
// Each step costs one register compare or one list or pair-bit memory access.
// An allocate searches the orders upward for a free block, unlinks it and
// splits it down to the order asked for. A free toggles the pair bit and
// merges with the free buddy, order by order, before it pushes the block.
// A rejected transaction is answered from idle. The pair-bit memory has one
// port. After reset it is cleared one entry a cycle, and busy stays high until then.
module buddy_page_allocator_top
	import bpa_pkg::*;
#(
	parameter int PAGES  = 4096,
	parameter int ORDERS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        op,
	input  logic [3:0]  order,
	input  logic [11:0] page_index,
	output logic        busy,
	output logic        done,
	output logic [1:0]  status,
	output logic [11:0] block_index
);

	localparam int AW = $clog2(PAGES);
	localparam int PW = AW + 1;
	localparam int KW = $clog2(ORDERS);
	localparam int EW = ((PW > 16) ? PW : 16) + 1;
	localparam logic [PW-1:0] NIL = PW'(PAGES);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_SRCH, S_UNL_RD, S_UNL_WR, S_TOG_RD, S_TOG_WR,
		S_SPLIT, S_FLOOP, S_PUSH1, S_PUSH2
	} state_t;

	state_t        state_q;
	logic          op_q, split_q, tv_q, done_q;
	logic [KW-1:0] ord_q, k_q;
	logic [AW-1:0] x_q, u_q, pb_q, clr_q;
	logic [PW-1:0] head_q [ORDERS];
	status_t       status_q;
	logic [11:0]   blk_q;

	logic [PW-1:0] nx_mem [PAGES];
	logic [PW-1:0] pv_mem [PAGES];
	logic          pr_mem [PAGES];
	logic [PW-1:0] nx_rd_q, pv_rd_q;
	logic          pr_rd_q;

	logic [PW-1:0] head_k, un_n, un_p;
	logic [PW:0]   bit_w;
	logic [AW-1:0] bsz;
	logic [EW-1:0] pg_e, sz_e;
	logic          misaligned;

	logic          nx_we, pv_we, pr_we, pr_wd;
	logic [AW-1:0] nx_wa, pv_wa, pr_wa;
	logic [PW-1:0] nx_wd, pv_wd;

	assign head_k = head_q[k_q];
	assign un_n   = (nx_rd_q > NIL) ? NIL : nx_rd_q;
	assign un_p   = pv_rd_q;
	assign bsz    = AW'(1) << k_q;
	assign bit_w  = (PW+1)'(PAGES) - ((PW+1)'(PAGES) >> k_q)
		+ (PW+1)'(x_q >> (k_q + 1));
	assign pg_e   = EW'(page_index);
	assign sz_e   = EW'(1) << order;
	assign misaligned = ((pg_e & (sz_e - EW'(1))) != '0) || (pg_e + sz_e > EW'(PAGES));

	always_comb begin
		nx_we = 1'b0;
		nx_wa = x_q;
		nx_wd = head_k;
		pv_we = 1'b0;
		pv_wa = x_q;
		pv_wd = NIL;
		pr_we = 1'b0;
		pr_wa = pb_q;
		pr_wd = ~pr_rd_q;
		unique case (state_q)
			S_UNL_WR: begin
				nx_we = un_p < NIL;
				nx_wa = un_p[AW-1:0];
				nx_wd = un_n;
				pv_we = un_n < NIL;
				pv_wa = un_n[AW-1:0];
				pv_wd = un_p;
			end
			S_PUSH1: begin
				nx_we = 1'b1;
				pv_we = 1'b1;
			end
			S_PUSH2: begin
				pv_we = head_k < NIL;
				pv_wa = head_k[AW-1:0];
				pv_wd = {1'b0, x_q};
			end
			S_CLR: begin
				pr_we = 1'b1;
				pr_wa = clr_q;
				pr_wd = 1'b0;
			end
			S_TOG_WR: begin
				pr_we = tv_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nx_we)
			nx_mem[nx_wa] <= nx_wd;
		if (pv_we)
			pv_mem[pv_wa] <= pv_wd;
		if (pr_we)
			pr_mem[pr_wa] <= pr_wd;
		if (state_q == S_UNL_RD) begin
			nx_rd_q <= nx_mem[u_q];
			pv_rd_q <= pv_mem[u_q];
		end
		if (state_q == S_TOG_RD)
			pr_rd_q <= pr_mem[bit_w[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			blk_q    <= '0;
			op_q     <= OP_ALLOC;
			split_q  <= 1'b0;
			tv_q     <= 1'b0;
			ord_q    <= '0;
			k_q      <= '0;
			x_q      <= '0;
			u_q      <= '0;
			pb_q     <= '0;
			for (int i = 0; i < ORDERS; i++)
				head_q[i] <= NIL;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(PAGES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						k_q     <= KW'(order);
						ord_q   <= KW'(order);
						x_q     <= pg_e[AW-1:0];
						split_q <= 1'b0;
						if (int'(order) >= ORDERS) begin
							done_q   <= 1'b1;
							status_q <= ST_BAD_ORDER;
							blk_q    <= '0;
						end else if (op == OP_ALLOC) begin
							state_q <= S_SRCH;
						end else if (misaligned) begin
							done_q   <= 1'b1;
							status_q <= ST_MISALIGNED;
							blk_q    <= '0;
						end else begin
							state_q <= S_FLOOP;
						end
					end
				end
				S_SRCH: begin
					if (head_k < NIL) begin
						u_q     <= head_k[AW-1:0];
						x_q     <= head_k[AW-1:0];
						state_q <= S_UNL_RD;
					end else if (k_q == KW'(ORDERS - 1)) begin
						done_q   <= 1'b1;
						status_q <= ST_NO_BLOCK;
						blk_q    <= '0;
						state_q  <= S_IDLE;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				S_UNL_RD: state_q <= S_UNL_WR;
				S_UNL_WR: begin
					if (!(un_p < NIL))
						head_q[k_q] <= un_n;
					if (op_q == OP_ALLOC) begin
						state_q <= (k_q != KW'(ORDERS - 1)) ? S_TOG_RD : S_SPLIT;
					end else begin
						x_q     <= x_q & ~bsz;
						k_q     <= k_q + KW'(1);
						state_q <= S_FLOOP;
					end
				end
				S_TOG_RD: begin
					tv_q    <= bit_w < (PW+1)'(PAGES);
					pb_q    <= bit_w[AW-1:0];
					state_q <= S_TOG_WR;
				end
				S_TOG_WR: begin
					if (op_q == OP_ALLOC) begin
						if (split_q)
							x_q <= x_q + bsz;
						state_q <= S_SPLIT;
					end else if (!(tv_q && pr_rd_q)) begin
						state_q <= S_PUSH1;
					end else begin
						u_q     <= x_q ^ bsz;
						state_q <= S_UNL_RD;
					end
				end
				S_SPLIT: begin
					if (k_q > ord_q) begin
						k_q     <= k_q - KW'(1);
						split_q <= 1'b1;
						state_q <= S_PUSH1;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						blk_q    <= 12'(EW'(x_q));
						state_q  <= S_IDLE;
					end
				end
				S_FLOOP: begin
					state_q <= (int'(k_q) < ORDERS - 1) ? S_TOG_RD : S_PUSH1;
				end
				S_PUSH1: state_q <= S_PUSH2;
				S_PUSH2: begin
					head_q[k_q] <= {1'b0, x_q};
					if (op_q == OP_ALLOC) begin
						state_q <= S_TOG_RD;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						blk_q    <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign block_index = blk_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted transaction neither worked nor answered");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> block_index == '0)
		else $error("failed transaction returned a block");

endmodule
